>>> rtl/dwsl_pkg.sv
package dwsl_pkg;

  // Field widths
  localparam int unsigned CountW  = 16;
  localparam int unsigned YawW    = 9;
  localparam int unsigned TgtW    = 11;
  localparam int unsigned GainW   = 8;
  localparam int unsigned LimW    = 15;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned AccW    = 16;
  localparam int unsigned BiasW   = 10;
  localparam int unsigned TurnW   = 20;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Register reset values
  localparam logic signed [TgtW-1:0] TargetSpeedRst = 11'sd10;
  localparam logic [GainW-1:0]       SpeedKpRst     = 8'd10;
  localparam logic [GainW-1:0]       SpeedKiRst     = 8'd50;
  localparam logic [GainW-1:0]       YawKpRst       = 8'd50;
  localparam logic [GainW-1:0]       YawKdRst       = 8'd0;
  localparam logic signed [YawW-1:0] YawOffsetRst   = 9'sd26;
  localparam logic [LimW-1:0]        SpeedLimitRst  = 15'd6500;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_SPEED = 3'd0,
    REG_SPEED_KP     = 3'd1,
    REG_SPEED_KI     = 3'd2,
    REG_YAW_KP       = 3'd3,
    REG_YAW_KD       = 3'd4,
    REG_YAW_OFFSET   = 3'd5,
    REG_SPEED_LIMIT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [AccW-1:0] accum;
    logic signed [ErrW-1:0] err;
  } loop_upd_t;

  typedef struct packed {
    logic             fwd;
    logic [DutyW-1:0] duty;
  } drive_t;

  // One incremental PI step with symmetric clamp.
  function automatic loop_upd_t speed_step(
    input logic signed [TgtW-1:0]   tgt,
    input logic signed [CountW-1:0] cnt,
    input logic signed [AccW-1:0]   accum,
    input logic signed [ErrW-1:0]   prev_err,
    input logic [GainW-1:0]         kp,
    input logic [GainW-1:0]         ki,
    input logic [LimW-1:0]          lim
  );
    logic signed [ErrW-1:0] err;
    logic signed [ErrW:0]   derr;
    logic signed [27:0]     p_term;
    logic signed [27:0]     i_term;
    logic signed [27:0]     acc;
    logic signed [27:0]     lim_pos;
    logic signed [27:0]     lim_neg;
    loop_upd_t              upd;
    err     = ErrW'(tgt) - ErrW'(cnt);
    derr    = (ErrW+1)'(err) - (ErrW+1)'(prev_err);
    p_term  = 28'($signed({1'b0, kp})) * 28'(derr);
    i_term  = 28'($signed({1'b0, ki})) * 28'(err);
    acc     = 28'(accum) + p_term + i_term;
    lim_pos = 28'($signed({1'b0, lim}));
    lim_neg = -lim_pos;
    if (acc > lim_pos) begin
      acc = lim_pos;
    end
    if (acc < lim_neg) begin
      acc = lim_neg;
    end
    upd.accum = acc[AccW-1:0];
    upd.err   = err;
    return upd;
  endfunction

  // Sign/magnitude split with saturation.
  function automatic drive_t drive(input logic signed [TurnW:0] cmd);
    logic signed [TurnW:0] mag;
    drive_t                d;
    mag   = cmd[TurnW] ? -cmd : cmd;
    d.fwd = !cmd[TurnW] && (cmd != '0);
    if (mag > (TurnW+1)'(65535)) begin
      d.duty = '1;
    end else begin
      d.duty = mag[DutyW-1:0];
    end
    return d;
  endfunction

endpackage

>>> rtl/differential_wheel_speed_loop.sv
// Channel | Dir | Ports                                 | Payload
// in      | in  | in_tvalid/in_tready/in_tdata/in_tuser | wheel counts, yaw sample, stop flag
// out     | out | out_tvalid/out_tready/out_tdata       | forward bits and duties per wheel
// cfg     | in  | cfg_wr_en/cfg_addr/cfg_wdata          | seven control registers
//
// One request per clock while the output is not stalled. The path is an input
// register, then the PI/PD math, then the result register; the loop state is updated
// in the same edge that loads the result register.
// rst_n (synchronous) restores the register defaults and zeroes loop state.
// A stalled output holds the pipe; the input register still accepts while the
// result register drains.
module differential_wheel_speed_loop
  import dwsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: left_count[15:0], right_count[31:16], yaw_angle[40:32], zero pad
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  // in_tuser: stopped[0]
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // out_tdata: left_forward[0], left_duty[16:1], right_forward[17],
  //            right_duty[33:18], zero pad
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgW-1:0]     cfg_wdata
);

  // Configuration registers
  logic signed [TgtW-1:0] target_speed_r;
  logic [GainW-1:0]       speed_kp_r;
  logic [GainW-1:0]       speed_ki_r;
  logic [GainW-1:0]       yaw_kp_r;
  logic [GainW-1:0]       yaw_kd_r;
  logic signed [YawW-1:0] yaw_offset_r;
  logic [LimW-1:0]        speed_limit_r;

  // Loop state
  logic signed [AccW-1:0]  left_accum_r,  left_accum_nxt;
  logic signed [ErrW-1:0]  left_err_r,    left_err_nxt;
  logic signed [AccW-1:0]  right_accum_r, right_accum_nxt;
  logic signed [ErrW-1:0]  right_err_r,   right_err_nxt;
  logic signed [BiasW-1:0] prev_bias_r,   bias_nxt;

  // Input register
  logic                     s1_valid_r;
  logic signed [CountW-1:0] s1_left_r;
  logic signed [CountW-1:0] s1_right_r;
  logic signed [YawW-1:0]   s1_yaw_r;
  logic                     s1_stop_r;

  // Result register
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  logic advance;
  logic upd_en;

  loop_upd_t               left_upd, right_upd;
  logic signed [BiasW:0]   dbias;
  logic signed [TurnW-1:0] turn;
  drive_t                  left_drv, right_drv;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign upd_en    = advance && s1_valid_r && !s1_stop_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Config writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_speed_r <= TargetSpeedRst;
      speed_kp_r     <= SpeedKpRst;
      speed_ki_r     <= SpeedKiRst;
      yaw_kp_r       <= YawKpRst;
      yaw_kd_r       <= YawKdRst;
      yaw_offset_r   <= YawOffsetRst;
      speed_limit_r  <= SpeedLimitRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TARGET_SPEED: target_speed_r <= cfg_wdata[TgtW-1:0];
        REG_SPEED_KP:     speed_kp_r     <= cfg_wdata[GainW-1:0];
        REG_SPEED_KI:     speed_ki_r     <= cfg_wdata[GainW-1:0];
        REG_YAW_KP:       yaw_kp_r       <= cfg_wdata[GainW-1:0];
        REG_YAW_KD:       yaw_kd_r       <= cfg_wdata[GainW-1:0];
        REG_YAW_OFFSET:   yaw_offset_r   <= cfg_wdata[YawW-1:0];
        REG_SPEED_LIMIT:  speed_limit_r  <= cfg_wdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Math between input and result registers
  always_comb begin
    left_upd  = speed_step(target_speed_r, s1_left_r, left_accum_r, left_err_r,
                           speed_kp_r, speed_ki_r, speed_limit_r);
    right_upd = speed_step(target_speed_r, s1_right_r, right_accum_r, right_err_r,
                           speed_kp_r, speed_ki_r, speed_limit_r);
    left_accum_nxt  = left_upd.accum;
    left_err_nxt    = left_upd.err;
    right_accum_nxt = right_upd.accum;
    right_err_nxt   = right_upd.err;

    // Steering PD on the offset yaw
    bias_nxt = BiasW'(s1_yaw_r) + BiasW'(yaw_offset_r);
    dbias    = (BiasW+1)'(bias_nxt) - (BiasW+1)'(prev_bias_r);
    turn     = TurnW'($signed({1'b0, yaw_kp_r})) * TurnW'(bias_nxt)
             + TurnW'($signed({1'b0, yaw_kd_r})) * TurnW'(dbias);

    left_drv  = drive((TurnW+1)'(left_accum_nxt) + (TurnW+1)'(turn));
    right_drv = drive((TurnW+1)'(right_accum_nxt) - (TurnW+1)'(turn));

    // Stop forces an all-zero result
    if (s1_stop_r) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt = {6'd0, right_drv.duty, right_drv.fwd, left_drv.duty, left_drv.fwd};
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_left_r  <= in_tdata[15:0];
      s1_right_r <= in_tdata[31:16];
      s1_yaw_r   <= in_tdata[40:32];
      s1_stop_r  <= in_tuser;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Loop state, frozen on stopped ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_accum_r  <= '0;
      left_err_r    <= '0;
      right_accum_r <= '0;
      right_err_r   <= '0;
      prev_bias_r   <= '0;
    end else if (upd_en) begin
      left_accum_r  <= left_accum_nxt;
      left_err_r    <= left_err_nxt;
      right_accum_r <= right_accum_nxt;
      right_err_r   <= right_err_nxt;
      prev_bias_r   <= bias_nxt;
    end
  end

  // A stopped request yields an all-zero result
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && s1_stop_r |=> out_tdata == '0 && out_tvalid)
    else $error("stopped request gave nonzero result");

  // A stopped request leaves the loop state alone
  a_stop_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && s1_stop_r |=>
      $stable(left_accum_r) && $stable(right_accum_r) && $stable(prev_bias_r))
    else $error("loop state changed on stopped request");

  // Accumulators stay inside the clamp after an update
  a_accum_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=>
      (32'(left_accum_r) <= $signed({17'd0, speed_limit_r})) &&
      (32'(left_accum_r) >= -$signed({17'd0, speed_limit_r})) &&
      (32'(right_accum_r) <= $signed({17'd0, speed_limit_r})) &&
      (32'(right_accum_r) >= -$signed({17'd0, speed_limit_r})))
    else $error("accumulator outside clamp");

  // No request is dropped: a held result blocks the input register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted over a blocked stage");

endmodule

>>> tb/tb_differential_wheel_speed_loop.sv
`timescale 1ns / 100ps

// Stream testbench for the two-wheel PI speed loop with PD yaw steering.
// A sender works through a queue of control ticks, a scoreboard predicts
// the drive command for every request it sees accepted and checks the
// results in order. Register writes happen only with the pipe
// empty.
module tb_differential_wheel_speed_loop;
  import dwsl_pkg::*;

  localparam int unsigned StallLimit = 2000;   // cycles with no request moving
  localparam longint      DutyMax    = 65535;
  localparam int          WHEEL_L    = 0;
  localparam int          WHEEL_R    = 1;
  // Index past the last register: the block must drop writes to it.
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [CountW-1:0] lc;
    logic [CountW-1:0] rc;
    logic [YawW-1:0]   yaw;
    logic              stop;
  } tick_t;

  typedef struct packed {
    logic             lf;
    logic [DutyW-1:0] ld;
    logic             rf;
    logic [DutyW-1:0] rd;
  } wheel_cmd_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr   = '0;
  logic [CfgW-1:0]     cfg_wdata  = '0;

  differential_wheel_speed_loop DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    // in_tdata: left_count[15:0], right_count[31:16], yaw_angle[40:32], zero pad
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    // in_tuser: stopped[0]
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // out_tdata: left_forward[0], left_duty[16:1], right_forward[17],
    //            right_duty[33:18], zero pad
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow registers, decoded to plain integers (signed ones sign-extended)
  // ---------------------------------------------------------------------------
  longint tgt_c     = longint'(TargetSpeedRst);
  longint spd_kp_c  = longint'(SpeedKpRst);
  longint spd_ki_c  = longint'(SpeedKiRst);
  longint yaw_kp_c  = longint'(YawKpRst);
  longint yaw_kd_c  = longint'(YawKdRst);
  longint yaw_off_c = longint'(YawOffsetRst);
  longint lim_c     = longint'(SpeedLimitRst);

  // Loop state mirrored per wheel; all zero out of reset
  longint accum_s[2]  = '{0, 0};
  longint perr_s[2]   = '{0, 0};
  longint prev_bias_s = 0;

  tick_t      tick_queue[$];     // ticks waiting to be driven
  wheel_cmd_t cmd_expected[$];   // predicted commands, oldest first

  int   n_errors     = 0;
  int   n_ticks      = 0;
  int   n_stops      = 0;
  int   n_results    = 0;
  int   n_settings   = 1;
  int   idle_pct     = 0;        // chance (percent) of starting an idle burst
  int   in_gap       = 0;
  int   out_gap      = 0;
  int   quiet_cycles = 0;
  logic in_taken     = 1'b0;     // input request accepted at the last edge
  logic drained      = 1'b0;     // nothing queued, in flight or outstanding

  // ---------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------
  // Incremental PI step: accumulate kp*delta_err + ki*err, then clamp.
  function automatic longint pi_update(int w, longint cnt);
    longint err;
    longint acc;
    err = tgt_c - cnt;
    acc = accum_s[w] + spd_kp_c * (err - perr_s[w]) + spd_ki_c * err;
    perr_s[w] = err;
    if (acc > lim_c) begin
      acc = lim_c;
    end
    if (acc < -lim_c) begin
      acc = -lim_c;
    end
    accum_s[w] = acc;
    return acc;
  endfunction

  // {forward, duty}: forward only for a strictly positive command
  function automatic logic [DutyW:0] wheel_drive(longint cmd);
    longint mag;
    mag = (cmd < 0) ? -cmd : cmd;
    return {cmd > 0, (mag > DutyMax) ? DutyW'(DutyMax) : DutyW'(mag)};
  endfunction

  function automatic wheel_cmd_t step_wheels(tick_t t);
    longint     bias;
    longint     turn;
    longint     lcmd;
    longint     rcmd;
    wheel_cmd_t c;
    c = '0;
    // A stopped tick gives an all-zero command and freezes every loop.
    if (!t.stop) begin
      bias = longint'($signed(t.yaw)) + yaw_off_c;
      turn = yaw_kp_c * bias + yaw_kd_c * (bias - prev_bias_s);
      prev_bias_s = bias;
      lcmd = pi_update(WHEEL_L, longint'($signed(t.lc))) + turn;
      rcmd = pi_update(WHEEL_R, longint'($signed(t.rc))) - turn;
      {c.lf, c.ld} = wheel_drive(lcmd);
      {c.rf, c.rd} = wheel_drive(rcmd);
    end
    return c;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: register shadow, prediction and result check, all at posedge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    tick_t      t;
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_TARGET_SPEED: tgt_c     = longint'($signed(cfg_wdata[TgtW-1:0]));
          REG_SPEED_KP:     spd_kp_c  = longint'(cfg_wdata[GainW-1:0]);
          REG_SPEED_KI:     spd_ki_c  = longint'(cfg_wdata[GainW-1:0]);
          REG_YAW_KP:       yaw_kp_c  = longint'(cfg_wdata[GainW-1:0]);
          REG_YAW_KD:       yaw_kd_c  = longint'(cfg_wdata[GainW-1:0]);
          REG_YAW_OFFSET:   yaw_off_c = longint'($signed(cfg_wdata[YawW-1:0]));
          REG_SPEED_LIMIT:  lim_c     = longint'(cfg_wdata[LimW-1:0]);
          default: ;   // unmapped index, dropped
        endcase
      end

      // Check before predicting: a result can never belong to a request
      // accepted on the same edge.
      if (out_tvalid && out_tready) begin
        got.lf = out_tdata[0];
        got.ld = out_tdata[16:1];
        got.rf = out_tdata[17];
        got.rd = out_tdata[33:18];
        if (cmd_expected.size() == 0) begin
          report_error($sformatf("unexpected result, out_tdata=%h", out_tdata));
        end else begin
          want = cmd_expected.pop_front();
          if (got.lf !== want.lf)
            report_error($sformatf("result %0d left_forward: got %b, expected %b",
                                   n_results, got.lf, want.lf));
          if (got.ld !== want.ld)
            report_error($sformatf("result %0d left_duty: got %0d, expected %0d",
                                   n_results, got.ld, want.ld));
          if (got.rf !== want.rf)
            report_error($sformatf("result %0d right_forward: got %b, expected %b",
                                   n_results, got.rf, want.rf));
          if (got.rd !== want.rd)
            report_error($sformatf("result %0d right_duty: got %0d, expected %0d",
                                   n_results, got.rd, want.rd));
        end
        n_results++;
      end

      if (in_tvalid && in_tready) begin
        t.lc   = in_tdata[15:0];
        t.rc   = in_tdata[31:16];
        t.yaw  = in_tdata[40:32];
        t.stop = in_tuser;
        cmd_expected.push_back(step_wheels(t));
        n_ticks++;
        if (t.stop) begin
          n_stops++;
        end
      end
    end
    in_taken <= rst_n && in_tvalid && in_tready;
    // An accepted request leaves an expectation behind, so it keeps this low.
    drained  <= (tick_queue.size() == 0) && (!in_tvalid || in_tready) &&
                (cmd_expected.size() == 0);
  end

  // ---------------------------------------------------------------------------
  // Sender: holds a request until accepted, idles in random bursts
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    tick_t t;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (tick_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        in_gap = $urandom_range(1, 18) - 1;
        in_tvalid <= 1'b0;
      end else begin
        t = tick_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= InDataW'({t.yaw, t.rc, t.lc});
        in_tuser  <= t.stop;
      end
    end
  end

  // Receiver: ready with random stall bursts; a burst left over from an
  // earlier phase is dropped once idling is switched off
  always @(negedge clk) begin
    if (rst_n) begin
      if (idle_pct == 0) begin
        out_gap = 0;
        out_tready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        out_gap = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any request, result or register write counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 quiet_cycles, cmd_expected.size());
        $display("differential_wheel_speed_loop test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_tick(int lc, int rc, int yaw, bit stop);
    tick_t t;
    t.lc   = CountW'(lc);
    t.rc   = CountW'(rc);
    t.yaw  = YawW'(yaw);
    t.stop = stop;
    tick_queue.push_back(t);
  endtask

  // Mostly counts close to the setpoint so the loops settle and move
  // rather than pinning at the clamp; some moderate, some full range.
  function automatic int rand_count();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      return int'(tgt_c) + int'($urandom_range(64)) - 32;
    end else if (sel < 8) begin
      return int'($urandom_range(400)) - 200;
    end
    return int'($urandom);
  endfunction

  task automatic queue_random(int n);
    int yaw;
    for (int i = 0; i < n; i++) begin
      yaw = ($urandom_range(99) < 85) ? int'($urandom_range(360)) - 180 : int'($urandom);
      queue_tick(rand_count(), rand_count(), yaw, $urandom_range(7) == 0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (!drained) begin
      @(negedge clk);
    end
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CfgW'(val);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // One write per register; a quarter carry junk in the unused upper bits.
  task automatic rand_settings();
    int val;
    for (int i = 0; i <= REG_SPEED_LIMIT; i++) begin
      if ($urandom_range(3) == 0) begin
        val = int'($urandom);
      end else begin
        unique case (cfg_reg_t'(i))
          REG_TARGET_SPEED: val = int'($urandom_range(2000)) - 1000;
          REG_YAW_OFFSET:   val = int'($urandom_range(360)) - 180;
          REG_SPEED_LIMIT:  val = int'($urandom_range(32767));
          default:          val = int'($urandom_range(255));
        endcase
      end
      cfg_write(CfgIdxW'(i), val);
    end
    cfg_release();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults. Error and bias both zero gives a zero command; a stop
    // in between must leave the state alone, so the repeat is zero too.
    idle_pct = 8;
    queue_tick(10, 10, -26, 0);
    queue_tick(-32768, 32767, -256, 1);
    queue_tick(10, 10, -26, 0);
    queue_tick(-32768, 32767, 180, 0);
    queue_tick(32767, -32768, -180, 0);
    queue_tick(0, 0, 255, 0);
    queue_tick(0, 0, -256, 0);
    queue_tick(32767, -32768, 255, 1);
    queue_tick(20, 0, 0, 0);
    queue_tick(-1, -1, -1, 0);
    queue_random(120);
    wait_drained();

    // Every register at its top end: both commands saturate, with opposite
    // sign. The spare index write must be dropped.
    idle_pct = 12;
    cfg_write(REG_TARGET_SPEED, 1023);
    cfg_write(REG_SPEED_KP, 255);
    cfg_write(REG_SPEED_KI, 255);
    cfg_write(REG_YAW_KP, 255);
    cfg_write(REG_YAW_KD, 255);
    cfg_write(REG_YAW_OFFSET, 255);
    cfg_write(REG_SPEED_LIMIT, 32767);
    cfg_write(REG_SPARE, -1);
    cfg_release();
    queue_tick(-32768, -32768, 255, 0);
    queue_tick(32767, 32767, -256, 0);
    queue_tick(1023, 1023, -255, 0);
    queue_tick(-32768, 32767, 255, 1);
    queue_tick(1023, -1023, 0, 0);
    queue_random(100);
    wait_drained();

    // Bottom end: zero gains and limit, most negative setpoint and offset.
    // Commands stay zero while the error history still moves.
    idle_pct = 4;
    cfg_write(REG_TARGET_SPEED, -1024);
    cfg_write(REG_SPEED_KP, 0);
    cfg_write(REG_SPEED_KI, 0);
    cfg_write(REG_YAW_KP, 0);
    cfg_write(REG_YAW_KD, 0);
    cfg_write(REG_YAW_OFFSET, -256);
    cfg_write(REG_SPEED_LIMIT, 0);
    cfg_release();
    queue_tick(0, 0, 0, 0);
    queue_tick(-32768, 32767, 255, 0);
    queue_random(60);
    wait_drained();

    // Random settings; heavy idling on one, none at all on the last.
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 3) ? 0 : ((p == 1) ? 20 : 6);
      rand_settings();
      queue_random(110);
      wait_drained();
    end

    // Give a stray extra result a chance to show up.
    repeat (8) @(negedge clk);

    $display("Ran %0d control ticks (%0d stopped) under %0d register settings, %0d results.",
             n_ticks, n_stops, n_settings, n_results);
    $display("Included saturated and zero commands, register extremes and random stalls.");
    if (n_errors == 0) begin
      $display("differential_wheel_speed_loop test passed");
    end else begin
      $display("differential_wheel_speed_loop test failed");
    end
    $finish;
  end

endmodule
